### design/hcb_pkg.sv
// shared types and constants for the hill cipher block core
`timescale 1ns / 1ps

package hcb_pkg;

    localparam int unsigned BYTES     = 4;
    localparam int unsigned KEY_BYTES = BYTES * BYTES;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 64;

    localparam logic [CFG_DAT_W-1:0] KEY_ROWS_LOW_RESET  = 64'h0000_0300_0000_0003;
    localparam logic [CFG_DAT_W-1:0] KEY_ROWS_HIGH_RESET = 64'h0300_0000_0003_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_ROWS_LOW  = 8'd0,
        CFG_KEY_ROWS_HIGH = 8'd1
    } cfg_reg_e;

    typedef logic [BYTES-1:0][7:0]     byte_vec_t;
    typedef logic [KEY_BYTES-1:0][7:0] key_mat_t;

    typedef struct packed {
        logic       last_in;
        logic [7:0] plain_byte3;
        logic [7:0] plain_byte2;
        logic [7:0] plain_byte1;
        logic [7:0] plain_byte0;
    } plain_t;

    typedef struct packed {
        logic       last_out;
        logic [7:0] cipher_byte3;
        logic [7:0] cipher_byte2;
        logic [7:0] cipher_byte1;
        logic [7:0] cipher_byte0;
    } cipher_t;

    // data handed from one cell to the next
    typedef struct packed {
        byte_vec_t sums;
        byte_vec_t plain;
        logic      last;
    } cell_data_t;

endpackage

### design/hcb_key_regs.sv
// key matrix configuration registers
`timescale 1ns / 1ps

module hcb_key_regs
    import hcb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output key_mat_t             key_mat
);

    logic [CFG_DAT_W-1:0] key_low_reg;
    logic [CFG_DAT_W-1:0] key_high_reg;
    logic [CFG_DAT_W-1:0] key_low_next;
    logic [CFG_DAT_W-1:0] key_high_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_ROWS_LOW:  key_low_next  = cfg_data;
                CFG_KEY_ROWS_HIGH: key_high_next = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= KEY_ROWS_LOW_RESET;
            key_high_reg <= KEY_ROWS_HIGH_RESET;
        end
        else
        begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
        end
    end

    assign key_mat = {key_high_reg, key_low_reg};

endmodule

### design/hcb_cell.sv
// one column cell: multiplies the head byte by a key column, adds to the row sums
`timescale 1ns / 1ps

module hcb_cell
    import hcb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  byte_vec_t  key_col,
    input  logic       in_valid,
    output logic       in_ready,
    input  cell_data_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output cell_data_t out_data
);

    logic       valid_reg;
    logic       valid_next;
    cell_data_t data_reg;
    cell_data_t data_next;
    logic       load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        logic [7:0] prod;
        prod      = '0;
        data_next = data_reg;
        if (load)
        begin
            for (int r = 0; r < BYTES; r++)
            begin
                // only the low byte of the product matters modulo 256
                prod = key_col[r] * in_data.plain[0];
                data_next.sums[r] = in_data.sums[r] + prod;
            end
            // consumed byte drops off, the rest move toward the head
            data_next.plain = {8'd0, in_data.plain[BYTES-1:1]};
            data_next.last  = in_data.last;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("cell dropped or changed a held transaction");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> in_ready)
        else $error("empty cell refused a transaction");

    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (valid_reg && data_reg.plain[BYTES-1] == 8'd0
                  && data_reg.last == $past(in_data.last)))
        else $error("loaded transaction not captured correctly");

endmodule

### design/hill_cipher_block_4x4_core.sv
// top level of the 4x4 hill cipher block core, a chain of four column cells
`timescale 1ns / 1ps

// usage
//   plain channel: plain_valid / plain_stall / plain carry one 4-byte block per
//   transaction; a transaction completes when plain_valid is high and plain_stall low
//   cipher channel: cipher_valid / cipher_stall / cipher return one block per input
//   block, in order, with last_out copied from last_in
//   cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data write the key;
//   index 0 holds key rows zero and one, index 1 rows two and three; other
//   indexes are ignored; write only while no block is in flight
// pipeline and throughput
//   one register stage per cell; each cell does four 8x8 products and adds
//   one block per cycle sustained while cipher_stall is low
// reset
//   rst_n low empties the chain and loads the key with three times identity
// stall
//   a stalled result holds in the last cell; earlier cells keep filling bubbles,
//   so plain_stall rises only once all four cells are occupied

module hill_cipher_block_4x4_core
    import hcb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 plain_valid,
    output logic                 plain_stall,
    input  plain_t               plain,
    output logic                 cipher_valid,
    input  logic                 cipher_stall,
    output cipher_t              cipher,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    key_mat_t key_mat;

    // chain links: link c feeds cell c, link BYTES is the chain output
    logic       link_valid [BYTES+1];
    logic       link_ready [BYTES+1];
    cell_data_t link_data  [BYTES+1];

    hcb_key_regs u_key_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_mat   (key_mat)
    );

    // head of the chain: sums start at zero, plain bytes queued byte0 first
    assign link_valid[0]      = plain_valid;
    assign plain_stall        = !link_ready[0];
    assign link_data[0].sums  = '0;
    assign link_data[0].plain = {plain.plain_byte3, plain.plain_byte2,
                                 plain.plain_byte1, plain.plain_byte0};
    assign link_data[0].last  = plain.last_in;

    for (genvar c = 0; c < BYTES; c++)
    begin : g_cell
        byte_vec_t key_col;

        // column c of the row-major key
        for (genvar r = 0; r < BYTES; r++)
        begin : g_col
            assign key_col[r] = key_mat[r*BYTES + c];
        end

        hcb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .key_col   (key_col),
            .in_valid  (link_valid[c]),
            .in_ready  (link_ready[c]),
            .in_data   (link_data[c]),
            .out_valid (link_valid[c+1]),
            .out_ready (link_ready[c+1]),
            .out_data  (link_data[c+1])
        );
    end

    // tail of the chain drives the result channel
    assign cipher_valid        = link_valid[BYTES];
    assign link_ready[BYTES]   = !cipher_stall;
    assign cipher.cipher_byte0 = link_data[BYTES].sums[0];
    assign cipher.cipher_byte1 = link_data[BYTES].sums[1];
    assign cipher.cipher_byte2 = link_data[BYTES].sums[2];
    assign cipher.cipher_byte3 = link_data[BYTES].sums[3];
    assign cipher.last_out     = link_data[BYTES].last;

endmodule

### dv/testbench.sv
// self-checking testbench for the 4x4 hill cipher block core, scoreboard class and stimulus
`timescale 1ns / 1ps

import hcb_pkg::*;

// tracks the key matrix and the cipher blocks still owed by the core
class hill_scoreboard;
    key_mat_t key;
    cipher_t  expected_ciphers[$];
    int       errors;

    function new();
        key    = {KEY_ROWS_HIGH_RESET, KEY_ROWS_LOW_RESET};
        errors = 0;
    endfunction

    function void load_key_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        if (idx == CFG_KEY_ROWS_LOW)
            key[7:0] = val;
        else if (idx == CFG_KEY_ROWS_HIGH)
            key[15:8] = val;
    endfunction

    // matrix times column vector, every sum wraps at 8 bits
    function cipher_t hill_product(plain_t p);
        byte_vec_t pv;
        byte_vec_t cv;
        cipher_t   c;
        pv = {p.plain_byte3, p.plain_byte2, p.plain_byte1, p.plain_byte0};
        for (int row = 0; row < BYTES; row++)
        begin
            cv[row] = 8'd0;
            for (int col = 0; col < BYTES; col++)
                cv[row] = cv[row] + key[row * BYTES + col] * pv[col];
        end
        c.cipher_byte0 = cv[0];
        c.cipher_byte1 = cv[1];
        c.cipher_byte2 = cv[2];
        c.cipher_byte3 = cv[3];
        c.last_out     = p.last_in;
        return c;
    endfunction

    function void note_plain(plain_t p);
        expected_ciphers.push_back(hill_product(p));
    endfunction

    function void check_cipher(cipher_t got);
        cipher_t want;
        if (expected_ciphers.size() == 0)
        begin
            $error("cipher transaction with no block expected: %0h", got);
            errors++;
            return;
        end
        want = expected_ciphers.pop_front();
        if (got.cipher_byte0 !== want.cipher_byte0)
        begin
            $error("cipher_byte0 expected %0h actual %0h", want.cipher_byte0, got.cipher_byte0);
            errors++;
        end
        if (got.cipher_byte1 !== want.cipher_byte1)
        begin
            $error("cipher_byte1 expected %0h actual %0h", want.cipher_byte1, got.cipher_byte1);
            errors++;
        end
        if (got.cipher_byte2 !== want.cipher_byte2)
        begin
            $error("cipher_byte2 expected %0h actual %0h", want.cipher_byte2, got.cipher_byte2);
            errors++;
        end
        if (got.cipher_byte3 !== want.cipher_byte3)
        begin
            $error("cipher_byte3 expected %0h actual %0h", want.cipher_byte3, got.cipher_byte3);
            errors++;
        end
        if (got.last_out !== want.last_out)
        begin
            $error("last_out expected %0h actual %0h", want.last_out, got.last_out);
            errors++;
        end
    endfunction

    function int outstanding();
        return expected_ciphers.size();
    endfunction
endclass

module testbench;

    // indexes above the two key registers must be ignored by the core
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 8'hFF;
    // cycles the cipher side holds off to back the chain up into plain_stall
    localparam int HOLD_CYCLES = 60;
    // cycles with no transaction on any channel before the run is declared hung
    localparam int STALL_LIMIT = 1000;
    // pipeline depth from the usage notes; doubled at the end as margin for the drain
    localparam int LATENCY     = 4;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 plain_valid  = 1'b0;
    logic                 plain_stall;
    plain_t               plain        = '0;
    logic                 cipher_valid;
    logic                 cipher_stall = 1'b0;
    cipher_t              cipher;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_DAT_W-1:0] cfg_data     = '0;

    // idle rates in percent, changed by the main sequence per phase
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // request for one long hold-off on the cipher side, counted down below
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    hill_scoreboard sb;

    hill_cipher_block_4x4_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .plain_valid  (plain_valid),
        .plain_stall  (plain_stall),
        .plain        (plain),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cipher       (cipher),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // cipher side backpressure: random stalls, or a counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request <= 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            cipher_stall <= 1'b1;
        end
        else
            cipher_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // every cipher transaction goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && cipher_valid && !cipher_stall)
            sb.check_cipher(cipher);
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((plain_valid && !plain_stall) || (cipher_valid && !cipher_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // bytes lean toward the extremes so wrap-around and zero rows show up often
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_key_word();
        logic [CFG_DAT_W-1:0] w;
        for (int i = 0; i < 8; i++)
            w[i*8 +: 8] = pick_byte();
        return w;
    endfunction

    function automatic plain_t pick_block();
        plain_t p;
        p.plain_byte0 = pick_byte();
        p.plain_byte1 = pick_byte();
        p.plain_byte2 = pick_byte();
        p.plain_byte3 = pick_byte();
        p.last_in     = ($urandom_range(3) == 0);
        return p;
    endfunction

    // offer one block, holding it until the plain transaction completes;
    // valid stays high afterwards so back-to-back blocks need no extra edge
    task automatic send_block(plain_t p);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            plain_valid <= 1'b0;
            @(posedge clk);
        end
        plain       <= p;
        plain_valid <= 1'b1;
        do
            @(posedge clk);
        while (plain_stall);
        sb.note_plain(p);
    endtask

    task automatic send_bytes(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                              logic [7:0] b3, logic last);
        plain_t p;
        p.plain_byte0 = b0;
        p.plain_byte1 = b1;
        p.plain_byte2 = b2;
        p.plain_byte3 = b3;
        p.last_in     = last;
        send_block(p);
    endtask

    task automatic send_random_blocks(int count);
        for (int i = 0; i < count; i++)
            send_block(pick_block());
    endtask

    // sender goes quiet until the core has returned every block
    task automatic wait_ciphers_drained();
        plain_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // one cfg transaction; valid stays high for a following write
    task automatic write_key_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.load_key_reg(idx, val);
    endtask

    task automatic end_key_writes();
        cfg_valid <= 1'b0;
    endtask

    // new random key, registers in random order, sometimes a stray index
    task automatic load_random_key();
        if ($urandom_range(2) == 0)
            write_key_reg(8'($urandom_range(255, 2)), pick_key_word());
        if ($urandom_range(1) == 0)
        begin
            write_key_reg(CFG_KEY_ROWS_LOW, pick_key_word());
            write_key_reg(CFG_KEY_ROWS_HIGH, pick_key_word());
        end
        else
        begin
            write_key_reg(CFG_KEY_ROWS_HIGH, pick_key_word());
            write_key_reg(CFG_KEY_ROWS_LOW, pick_key_word());
        end
        end_key_writes();
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset key is three times identity: each byte tripled mod 256
        send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_bytes(8'h01, 8'h02, 8'h04, 8'h08, 1'b0);
        send_bytes(8'h80, 8'h40, 8'h20, 8'h10, 1'b1);
        send_bytes(8'h55, 8'hAA, 8'h56, 8'hAB, 1'b0);
        send_bytes(8'h7F, 8'hFE, 8'hFD, 8'hFC, 1'b1);

        // write to an unmapped index must leave the key untouched
        wait_ciphers_drained();
        write_key_reg(CFG_IDX_UNMAPPED, '1);
        end_key_writes();
        send_bytes(8'hC3, 8'h3C, 8'h99, 8'h66, 1'b0);

        // all-ones key, singular and maximal
        wait_ciphers_drained();
        write_key_reg(CFG_KEY_ROWS_LOW, '1);
        write_key_reg(CFG_KEY_ROWS_HIGH, '1);
        end_key_writes();
        send_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_bytes(8'h01, 8'h01, 8'h01, 8'h01, 1'b0);
        send_bytes(8'h80, 8'h80, 8'h80, 8'h7F, 1'b1);

        // zero key, every cipher byte collapses to zero
        wait_ciphers_drained();
        write_key_reg(CFG_KEY_ROWS_HIGH, '0);
        write_key_reg(CFG_KEY_ROWS_LOW, '0);
        end_key_writes();
        send_bytes(8'hFF, 8'hA5, 8'h5A, 8'h01, 1'b1);
        send_bytes(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);

        // identity key, block passes straight through
        wait_ciphers_drained();
        write_key_reg(CFG_KEY_ROWS_LOW, 64'h0000_0100_0000_0001);
        write_key_reg(CFG_KEY_ROWS_HIGH, 64'h0100_0000_0001_0000);
        end_key_writes();
        send_bytes(8'hDE, 8'hAD, 8'hBE, 8'hEF, 1'b0);
        send_bytes(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);

        // distinct entry per position, catches swapped rows or columns
        wait_ciphers_drained();
        write_key_reg(CFG_KEY_ROWS_LOW, 64'h0807_0605_0403_0201);
        write_key_reg(CFG_KEY_ROWS_HIGH, 64'h100F_0E0D_0C0B_0A09);
        end_key_writes();
        send_bytes(8'h01, 8'h00, 8'h00, 8'h00, 1'b0);
        send_bytes(8'h00, 8'h00, 8'h00, 8'h01, 1'b1);
        send_bytes(8'h10, 8'h20, 8'h30, 8'h40, 1'b0);

        // random part, three idle regimes with two keys each
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 77;
                end
                1:
                begin
                    tx_idle_pct = 77;
                    rx_idle_pct = 7;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int ph = 0; ph < 2; ph++)
            begin
                wait_ciphers_drained();
                load_random_key();
                send_random_blocks(65);
            end
            if (mode == 0)
            begin
                // long cipher hold-off while blocks keep coming: chain fills, plain stalls
                tx_idle_pct = 0;
                hold_request <= 1'b1;
                send_random_blocks(24);
            end
        end

        // leave the core on its reset key values and run a last few blocks
        wait_ciphers_drained();
        write_key_reg(CFG_KEY_ROWS_LOW, KEY_ROWS_LOW_RESET);
        write_key_reg(CFG_KEY_ROWS_HIGH, KEY_ROWS_HIGH_RESET);
        end_key_writes();
        send_random_blocks(8);

        wait_ciphers_drained();
        repeat (2 * LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
